// File: hw/rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the framed serial receiver with CRC-32.
// ----------------------------------------------------------------------------
package sfr_pkg;

  // Reflected CRC-32 polynomial and the inverted initial value
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // Number of offset bytes that the length of a blob frame counts
  localparam logic [31:0] OFS_BYTES = 32'd4;

  // Result kinds seen on the output channel
  localparam logic [1:0] RES_TEXT = 2'd0;
  localparam logic [1:0] RES_HALF = 2'd1;
  localparam logic [1:0] RES_DONE = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_STRING = 2'd0;
  localparam logic [1:0] CFG_BINARY = 2'd1;
  localparam logic [1:0] CFG_BOOT   = 2'd2;

  // Parser phases
  typedef enum logic [2:0] {
    PH_TYPE,
    PH_LEN,
    PH_OFS,
    PH_PAY,
    PH_CRC
  } sfr_phase_t;

  // Work handed from the parser to the emitter
  typedef enum logic [1:0] {
    OP_TEXT,
    OP_BYTE,
    OP_DONE
  } sfr_op_kind_t;

  typedef struct packed {
    logic [7:0] string_code;
    logic [7:0] binary_code;
    logic [7:0] boot_code;
  } sfr_cfg_t;

  typedef struct packed {
    sfr_op_kind_t kind;
    logic [7:0]   data;
    logic [31:0]  addr;
    logic [7:0]   frame_type;
    logic         status;
    logic [31:0]  plen;
    logic         misaligned;
    logic         len_short;
  } sfr_op_t;

  // One byte of the reflected CRC-32 update
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/sfr_parser.sv
// ----------------------------------------------------------------------------
// sfr_parser
// Front end: takes received bytes, walks the frame header, keeps the running
// CRC and payload index, and queues one request per byte that has work.
// ----------------------------------------------------------------------------
module sfr_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  sfr_pkg::sfr_cfg_t cfg,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_rx_byte,
  input  logic            q_full,
  output logic            q_push,
  output sfr_pkg::sfr_op_t q_op
);
  import sfr_pkg::*;

  sfr_phase_t  phase_r, phase_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic [7:0]  held_type_r, held_type_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] ofs_r, ofs_nxt;
  logic [31:0] idx_r, idx_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] scrc_r, scrc_nxt;

  logic        accept;
  logic        is_blob;
  logic        is_text;
  logic        pos_last;
  logic [31:0] len_shift;
  logic [31:0] ofs_shift;
  logic [31:0] scrc_shift;
  logic [31:0] crc_upd;
  logic [31:0] len_cnt;
  logic [31:0] plen;
  logic [31:0] idx_inc;
  logic        pay_end;

  // Input side stalls only on a full queue
  assign in_stall = q_full;
  assign accept   = in_valid & ~q_full;

  // Frame classification against the live type codes
  assign is_blob = (held_type_r == cfg.binary_code) || (held_type_r == cfg.boot_code);
  assign is_text = (held_type_r == cfg.string_code);

  // Little-endian field capture
  assign len_shift  = {in_rx_byte, len_r[31:8]};
  assign ofs_shift  = {in_rx_byte, ofs_r[31:8]};
  assign scrc_shift = {in_rx_byte, scrc_r[31:8]};
  assign crc_upd    = crc32_byte(crc_r, in_rx_byte);
  assign pos_last   = (pos_r == 2'd3);

  // Payload count: blob lengths include the offset and saturate at zero
  assign len_cnt = (phase_r == PH_LEN) ? len_shift : len_r;
  always_comb begin
    if (!is_blob) begin
      plen = len_cnt;
    end else if (len_cnt < OFS_BYTES) begin
      plen = '0;
    end else begin
      plen = len_cnt - OFS_BYTES;
    end
  end

  assign idx_inc = idx_r + 32'd1;
  assign pay_end = (idx_inc >= plen);

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      case (phase_r)
        PH_LEN: begin
          if (pos_last) begin
            if (is_blob) begin
              phase_nxt = PH_OFS;
            end else begin
              phase_nxt = (plen == '0) ? PH_CRC : PH_PAY;
            end
          end
        end
        PH_OFS: begin
          if (pos_last) begin
            phase_nxt = (plen == '0) ? PH_CRC : PH_PAY;
          end
        end
        PH_PAY: begin
          if (pay_end) begin
            phase_nxt = PH_CRC;
          end
        end
        PH_CRC: begin
          if (pos_last) begin
            phase_nxt = PH_TYPE;
          end
        end
        default: begin
          phase_nxt = PH_LEN;
        end
      endcase
    end
  end

  // Datapath updates and queued requests
  always_comb begin
    pos_nxt       = pos_r;
    held_type_nxt = held_type_r;
    len_nxt       = len_r;
    ofs_nxt       = ofs_r;
    idx_nxt       = idx_r;
    crc_nxt       = crc_r;
    scrc_nxt      = scrc_r;
    q_push        = 1'b0;
    q_op          = '0;
    q_op.frame_type = held_type_r;
    q_op.data       = in_rx_byte;
    if (accept) begin
      case (phase_r)
        PH_LEN: begin
          len_nxt = len_shift;
          pos_nxt = pos_r + 2'd1;
          if (pos_last) begin
            ofs_nxt = '0;
            idx_nxt = '0;
          end
        end
        PH_OFS: begin
          crc_nxt = crc_upd;
          ofs_nxt = ofs_shift;
          pos_nxt = pos_r + 2'd1;
          if (pos_last) begin
            idx_nxt = '0;
          end
        end
        PH_PAY: begin
          crc_nxt = crc_upd;
          idx_nxt = idx_inc;
          if (pay_end) begin
            pos_nxt = '0;
          end
          // text check wins when codes overlap
          if (is_text) begin
            q_push     = 1'b1;
            q_op.kind  = OP_TEXT;
          end else if (is_blob) begin
            q_push     = 1'b1;
            q_op.kind  = OP_BYTE;
            q_op.addr  = ofs_r + idx_r;
          end
        end
        PH_CRC: begin
          scrc_nxt = scrc_shift;
          pos_nxt  = pos_r + 2'd1;
          if (pos_last) begin
            q_push          = 1'b1;
            q_op.kind       = OP_DONE;
            q_op.data       = '0;
            q_op.status     = (scrc_shift != ~crc_r);
            q_op.plen       = plen;
            q_op.misaligned = is_blob & (len_r[0] | ofs_r[0]);
            q_op.len_short  = is_blob & (len_r < OFS_BYTES);
          end
        end
        default: begin
          held_type_nxt = in_rx_byte;
          len_nxt       = '0;
          ofs_nxt       = '0;
          idx_nxt       = '0;
          scrc_nxt      = '0;
          crc_nxt       = CRC_INIT;
          pos_nxt       = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TYPE;
      pos_r       <= '0;
      held_type_r <= '0;
      len_r       <= '0;
      ofs_r       <= '0;
      idx_r       <= '0;
      crc_r       <= CRC_INIT;
      scrc_r      <= '0;
    end else begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      held_type_r <= held_type_nxt;
      len_r       <= len_nxt;
      ofs_r       <= ofs_nxt;
      idx_r       <= idx_nxt;
      crc_r       <= crc_nxt;
      scrc_r      <= scrc_nxt;
    end
  end

endmodule

// File: hw/rtl/sfr_fifo.sv
// ----------------------------------------------------------------------------
// sfr_fifo
// Short request queue between the parser and the emitter.
// ----------------------------------------------------------------------------
module sfr_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  sfr_pkg::sfr_op_t wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic             rd_valid,
  output sfr_pkg::sfr_op_t rd_data
);
  import sfr_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  sfr_op_t          slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == CNT_FULL);
  assign rd_valid = (count_r != '0);
  assign rd_data  = slot_r[rd_ptr_r];

  // Pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (!wr_en && rd_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  // Checks
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !full)
    else $error("request queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> rd_valid)
    else $error("request queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("request queue count beyond depth");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && !rd_en) |=> (count_r == $past(count_r) + 1'b1))
    else $error("request queue count did not follow a write");

  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    (!wr_en && rd_en) |=> (count_r == $past(count_r) - 1'b1))
    else $error("request queue count did not follow a read");

endmodule

// File: hw/rtl/sfr_emitter.sv
// ----------------------------------------------------------------------------
// sfr_emitter
// Back end: drains queued requests, pairs blob bytes into halfword writes
// and holds each result in an output register until it is taken.
// ----------------------------------------------------------------------------
module sfr_emitter (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  sfr_pkg::sfr_op_t q_op,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_result_kind,
  output logic [15:0]      out_data_value,
  output logic [31:0]      out_write_address,
  output logic [7:0]       out_frame_type,
  output logic             out_frame_status,
  output logic [31:0]      out_payload_length,
  output logic             out_misaligned,
  output logic             out_length_short
);
  import sfr_pkg::*;

  logic        valid_r, valid_nxt;
  logic [7:0]  low_r, low_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [15:0] data_r, data_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [7:0]  type_r, type_nxt;
  logic        status_r, status_nxt;
  logic [31:0] plen_r, plen_nxt;
  logic        mis_r, mis_nxt;
  logic        short_r, short_nxt;

  logic can_load;
  logic emits;

  // Output register is free when empty or being taken this cycle
  assign can_load = ~valid_r | ~out_stall;
  assign q_pop    = q_valid & can_load;

  // Build the result for the request at the queue head
  always_comb begin
    emits      = 1'b0;
    low_nxt    = low_r;
    kind_nxt   = kind_r;
    data_nxt   = data_r;
    addr_nxt   = addr_r;
    type_nxt   = type_r;
    status_nxt = status_r;
    plen_nxt   = plen_r;
    mis_nxt    = mis_r;
    short_nxt  = short_r;
    if (q_pop) begin
      type_nxt   = q_op.frame_type;
      status_nxt = 1'b0;
      plen_nxt   = '0;
      mis_nxt    = 1'b0;
      short_nxt  = 1'b0;
      addr_nxt   = '0;
      case (q_op.kind)
        OP_TEXT: begin
          emits    = 1'b1;
          kind_nxt = RES_TEXT;
          data_nxt = {8'h00, q_op.data};
        end
        OP_BYTE: begin
          // odd address closes a pair, even address is held
          if (q_op.addr[0]) begin
            emits    = 1'b1;
            kind_nxt = RES_HALF;
            data_nxt = {q_op.data, low_r};
            addr_nxt = {q_op.addr[31:1], 1'b0};
          end else begin
            low_nxt = q_op.data;
          end
        end
        OP_DONE: begin
          emits      = 1'b1;
          kind_nxt   = RES_DONE;
          data_nxt   = '0;
          status_nxt = q_op.status;
          plen_nxt   = q_op.plen;
          mis_nxt    = q_op.misaligned;
          short_nxt  = q_op.len_short;
        end
        default: begin
          emits = 1'b0;
        end
      endcase
    end
    valid_nxt = can_load ? (q_pop & emits) : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      low_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      low_r   <= low_nxt;
    end
  end

  // Result payload, loaded only when a result is produced
  always_ff @(posedge clk) begin
    if (q_pop && emits) begin
      kind_r   <= kind_nxt;
      data_r   <= data_nxt;
      addr_r   <= addr_nxt;
      type_r   <= type_nxt;
      status_r <= status_nxt;
      plen_r   <= plen_nxt;
      mis_r    <= mis_nxt;
      short_r  <= short_nxt;
    end
  end

  assign out_valid          = valid_r;
  assign out_result_kind    = kind_r;
  assign out_data_value     = data_r;
  assign out_write_address  = addr_r;
  assign out_frame_type     = type_r;
  assign out_frame_status   = status_r;
  assign out_payload_length = plen_r;
  assign out_misaligned     = mis_r;
  assign out_length_short   = short_r;

endmodule

// File: hw/rtl/serial_frame_receiver_crc32.sv
// ----------------------------------------------------------------------------
// serial_frame_receiver_crc32
// Framed serial receiver with a running CRC-32 over offset and payload bytes.
// ----------------------------------------------------------------------------
// Takes one received byte per request and parses frames of a type byte, a
// little-endian length, an offset for the two blob types, the payload and a
// 4-byte CRC. Text payload bytes come out one per request, blob bytes come out
// as halfword writes at even addresses, and the last CRC byte gives a frame
// complete result with status and length. A byte is taken every clock cycle
// unless the input stalls; the rate is set by the byte-wide CRC update in the
// parser. A result is written to the request queue at the edge that takes the
// byte causing it, then into the output register once that register is free.
// The input stalls only when the request queue is full, which happens when a
// result is held in the output register and FIFO_DEPTH more requests wait
// behind it.
// Type codes may be rewritten at any time the block is idle.
module serial_frame_receiver_crc32 #(
  parameter int unsigned FIFO_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [15:0] out_data_value,
  output logic [31:0] out_write_address,
  output logic [7:0]  out_frame_type,
  output logic        out_frame_status,
  output logic [31:0] out_payload_length,
  output logic        out_misaligned,
  output logic        out_length_short,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [7:0]  cfg_wdata
);
  import sfr_pkg::*;

  sfr_cfg_t cfg_r, cfg_nxt;
  sfr_op_t  push_op;
  sfr_op_t  head_op;
  logic     push;
  logic     q_full;
  logic     q_valid;
  logic     q_pop;

  // Type code registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_STRING: cfg_nxt.string_code = cfg_wdata;
        CFG_BINARY: cfg_nxt.binary_code = cfg_wdata;
        CFG_BOOT:   cfg_nxt.boot_code   = cfg_wdata;
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.string_code <= 8'd1;
      cfg_r.binary_code <= 8'd2;
      cfg_r.boot_code   <= 8'd3;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: header walk, CRC, classification
  sfr_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .q_push     (push),
    .q_op       (push_op)
  );

  // Request queue
  sfr_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (push),
    .wr_data  (push_op),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_data  (head_op)
  );

  // Back: pairing and result register
  sfr_emitter u_emitter (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_op               (head_op),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_kind    (out_result_kind),
    .out_data_value     (out_data_value),
    .out_write_address  (out_write_address),
    .out_frame_type     (out_frame_type),
    .out_frame_status   (out_frame_status),
    .out_payload_length (out_payload_length),
    .out_misaligned     (out_misaligned),
    .out_length_short   (out_length_short)
  );

endmodule
